[sv/stxrx_pkg.sv]
// stxrx_pkg: types, codes and reset values for the stx/etx/lrc frame receiver
// no dependencies; imported by the interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package stxrx_pkg;

	localparam logic [7:0] CODE_STX = 8'h02;
	localparam logic [7:0] CODE_ETX = 8'h03;

	localparam logic [31:0] START_TIMEOUT_RESET  = 32'd60000;
	localparam logic [15:0] LENGTH_TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] BYTE_TIMEOUT_RESET   = 16'd500;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_TIMEOUT  = 2'd0,
		REG_LENGTH_TIMEOUT = 2'd1,
		REG_BYTE_TIMEOUT   = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_BYTE = 2'd0,
		MODE_TICK = 2'd1,
		MODE_ARM  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_STX     = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_ETX     = 3'd5,
		PH_LRC     = 3'd6,
		PH_LRC_BAD = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TO_START = 3'd1,
		ST_TO_LEN   = 3'd2,
		ST_TO_BYTE  = 3'd3,
		ST_BAD_ETX  = 3'd4,
		ST_BAD_LRC  = 3'd5
	} status_t;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  payload_byte;
		logic [2:0]  frame_status;
		logic [15:0] frame_length;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

[sv/stxrx_if.sv]
// stxrx item, result and configuration channels, valid/ready handshake
// depends on stxrx_pkg for the configuration widths
`timescale 1ns / 1ps
`default_nettype none

interface stxrx_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface stxrx_result_if;
	logic        valid;
	logic        ready;
	logic        is_status;
	logic [7:0]  payload_byte;
	logic [2:0]  frame_status;
	logic [15:0] frame_length;
	logic        last;

	modport source (output valid, output is_status, output payload_byte,
		output frame_status, output frame_length, output last, input ready);
	modport sink (input valid, input is_status, input payload_byte,
		input frame_status, input frame_length, input last, output ready);
endinterface

interface stxrx_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [stxrx_pkg::CFG_INDEX_W-1:0] index;
	logic [stxrx_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/stx_etx_lrc_frame_receiver.sv]
// stx_etx_lrc_frame_receiver: frame parser with tick timeouts and lrc check
// depends on stxrx_pkg and the channel interfaces in stxrx_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Takes one item (received byte, tick or arm) in every cycle that item.ready
// is high; each item is handled in the cycle it is accepted by the phase
// register, a 32-bit tick compare and an xor, and any result goes to a
// one-deep output register backed by a one-entry skid stage. item.ready
// drops only while the skid stage is occupied, i.e. while two results are
// waiting on a stalled result channel. Payload bytes stream out as they
// arrive; one status item closes each frame not cut short by an arm item. The
// configuration port is always ready and should only be written while the block is idle.
module stx_etx_lrc_frame_receiver (
	input  wire             clk,
	input  wire             arst_n,
	stxrx_item_if.sink      item,
	stxrx_result_if.source  result,
	stxrx_cfg_if.sink       cfg
);
	import stxrx_pkg::*;

	logic [31:0] start_limit_q;
	logic [15:0] length_limit_q;
	logic [15:0] byte_limit_q;

	phase_t      phase_q, phase_d;
	logic [15:0] header_length_q, header_length_d;
	logic [15:0] bytes_seen_q, bytes_seen_d;
	logic [7:0]  check_q, check_d;
	logic [31:0] wait_q, wait_d;

	result_t     res;
	logic        res_valid;
	logic        accept;

	logic        out_valid_q;
	result_t     out_q;
	logic        skid_valid_q;
	result_t     skid_q;
	logic        out_fire;

	logic [31:0] limit;
	logic [31:0] wait_inc;
	logic [16:0] seen_inc;
	status_t     to_status;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_limit_q  <= START_TIMEOUT_RESET;
			length_limit_q <= LENGTH_TIMEOUT_RESET;
			byte_limit_q   <= BYTE_TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_START_TIMEOUT:  start_limit_q  <= cfg.data;
				REG_LENGTH_TIMEOUT: length_limit_q <= cfg.data[15:0];
				REG_BYTE_TIMEOUT:   byte_limit_q   <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	assign item.ready = !skid_valid_q;
	assign accept     = item.valid && item.ready;

	always_comb begin
		case (phase_q)
			PH_STX: begin
				limit     = start_limit_q;
				to_status = ST_TO_START;
			end
			PH_LEN_HI, PH_LEN_LO: begin
				limit     = {16'd0, length_limit_q};
				to_status = ST_TO_LEN;
			end
			default: begin
				limit     = {16'd0, byte_limit_q};
				to_status = ST_TO_BYTE;
			end
		endcase
	end

	assign wait_inc = wait_q + 32'd1;
	assign seen_inc = {1'b0, bytes_seen_q} + 17'd1;

	always_comb begin
		phase_d         = phase_q;
		header_length_d = header_length_q;
		bytes_seen_d    = bytes_seen_q;
		check_d         = check_q;
		wait_d          = wait_q;
		res_valid       = 1'b0;
		res.is_status    = 1'b1;
		res.payload_byte = 8'd0;
		res.frame_status = ST_OK;
		res.frame_length = header_length_q;
		res.last         = 1'b1;
		case (item.mode)
			MODE_ARM: begin
				phase_d         = PH_STX;
				header_length_d = 16'd0;
				bytes_seen_d    = 16'd0;
				check_d         = 8'd0;
				wait_d          = 32'd0;
			end
			MODE_TICK: begin
				if (phase_q != PH_IDLE) begin
					wait_d = wait_inc;
					if (wait_inc >= limit) begin
						res_valid        = 1'b1;
						res.frame_status = to_status;
						phase_d          = PH_IDLE;
						wait_d           = 32'd0;
					end
				end
			end
			MODE_BYTE: begin
				case (phase_q)
					PH_STX: begin
						if (item.rx_byte == CODE_STX) begin
							phase_d = PH_LEN_HI;
							wait_d  = 32'd0;
							check_d = 8'd0;
						end
					end
					PH_LEN_HI: begin
						header_length_d = {item.rx_byte, 8'd0};
						check_d         = check_q ^ item.rx_byte;
						phase_d         = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						header_length_d = {header_length_q[15:8], item.rx_byte};
						check_d         = check_q ^ item.rx_byte;
						bytes_seen_d    = 16'd0;
						wait_d          = 32'd0;
						phase_d = ({header_length_q[15:8], item.rx_byte} == 16'd0)
							? PH_ETX : PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						check_d      = check_q ^ item.rx_byte;
						bytes_seen_d = seen_inc[15:0];
						wait_d       = 32'd0;
						if (seen_inc >= {1'b0, header_length_q}) begin
							phase_d = PH_ETX;
						end
						res_valid        = 1'b1;
						res.is_status    = 1'b0;
						res.payload_byte = item.rx_byte;
						res.last         = 1'b0;
					end
					PH_ETX: begin
						check_d = check_q ^ item.rx_byte;
						wait_d  = 32'd0;
						phase_d = (item.rx_byte == CODE_ETX) ? PH_LRC : PH_LRC_BAD;
					end
					PH_LRC: begin
						res_valid        = 1'b1;
						res.frame_status = (item.rx_byte == check_q) ? ST_OK : ST_BAD_LRC;
						phase_d          = PH_IDLE;
						wait_d           = 32'd0;
					end
					PH_LRC_BAD: begin
						res_valid        = 1'b1;
						res.frame_status = ST_BAD_ETX;
						phase_d          = PH_IDLE;
						wait_d           = 32'd0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			header_length_q <= 16'd0;
			bytes_seen_q    <= 16'd0;
			check_q         <= 8'd0;
			wait_q          <= 32'd0;
		end else if (accept) begin
			phase_q         <= phase_d;
			header_length_q <= header_length_d;
			bytes_seen_q    <= bytes_seen_d;
			check_q         <= check_d;
			wait_q          <= wait_d;
		end
	end

	// output register with one-entry skid
	assign out_fire = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (accept && res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.is_status    = out_q.is_status;
	assign result.payload_byte = out_q.payload_byte;
	assign result.frame_status = out_q.frame_status;
	assign result.frame_length = out_q.frame_length;
	assign result.last         = out_q.last;

	// skid stage only fills behind a waiting output register
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while the output register is empty");

	// in the payload phase there is always at least one byte still to come
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_seen_q < header_length_q)
		else $error("payload count reached header length without leaving payload phase");

	// a status item closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res.is_status |=> phase_q == PH_IDLE && wait_q == 32'd0)
		else $error("receiver not idle after a status item");

	// a payload item is never a closing item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.is_status == out_q.last)
		else $error("last flag disagrees with item kind");

endmodule

`default_nettype wire

[test/tb.sv]
// tb: self-checking bench for stx_etx_lrc_frame_receiver, with a driver, a monitor and a frame predictor
// depends on stxrx_pkg, the channel interfaces in stxrx_if.sv and the top level
`timescale 1ns / 1ps

module tb;
	import stxrx_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned WATCHDOG_CYCLES = 2000;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
	} rx_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stxrx_item_if item_ch ();
	stxrx_result_if result_ch ();
	stxrx_cfg_if cfg_ch ();

	stx_etx_lrc_frame_receiver u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// receiver shadow
	phase_t      rcv_phase = PH_IDLE;
	logic [15:0] rcv_len = 16'd0;
	logic [16:0] rcv_count = 17'd0;
	logic [7:0]  rcv_lrc = 8'd0;
	logic [31:0] rcv_ticks = 32'd0;
	logic [31:0] lim_start = START_TIMEOUT_RESET;
	logic [15:0] lim_len = LENGTH_TIMEOUT_RESET;
	logic [15:0] lim_b = BYTE_TIMEOUT_RESET;

	rx_item_t    rx_items[$];
	result_t     frame_out_due[$];
	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned src_gap = 0;
	int unsigned snk_gap = 0;
	bit          src_flat = 1'b0;
	bit          snk_flat = 1'b0;
	rx_item_t    next_item;
	result_t     seen_res;
	result_t     due_res;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic close_frame(input status_t st);
		frame_out_due.push_back(result_t'{1'b1, 8'h00, st, rcv_len, 1'b1});
		rcv_phase = PH_IDLE;
		rcv_ticks = 32'd0;
	endtask

	task automatic advance_receiver(input logic [1:0] m, input logic [7:0] b);
		logic [31:0] lim;
		status_t     st;
		if (m == MODE_ARM) begin
			rcv_phase = PH_STX;
			rcv_len = 16'd0;
			rcv_count = 17'd0;
			rcv_lrc = 8'd0;
			rcv_ticks = 32'd0;
		end else if (m == MODE_TICK) begin
			if (rcv_phase != PH_IDLE) begin
				if (rcv_phase == PH_STX) begin
					lim = lim_start;
					st = ST_TO_START;
				end else if (rcv_phase == PH_LEN_HI || rcv_phase == PH_LEN_LO) begin
					lim = {16'd0, lim_len};
					st = ST_TO_LEN;
				end else begin
					lim = {16'd0, lim_b};
					st = ST_TO_BYTE;
				end
				rcv_ticks = rcv_ticks + 32'd1;
				if (rcv_ticks >= lim)
					close_frame(st);
			end
		end else if (m == MODE_BYTE) begin
			case (rcv_phase)
				PH_STX: begin
					if (b == CODE_STX) begin
						rcv_phase = PH_LEN_HI;
						rcv_ticks = 32'd0;
						rcv_lrc = 8'd0;
					end
				end
				PH_LEN_HI: begin
					rcv_len = {b, 8'h00};
					rcv_lrc = rcv_lrc ^ b;
					rcv_phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					rcv_len[7:0] = b;
					rcv_lrc = rcv_lrc ^ b;
					rcv_count = 17'd0;
					rcv_ticks = 32'd0;
					rcv_phase = (rcv_len == 16'd0) ? PH_ETX : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					rcv_lrc = rcv_lrc ^ b;
					rcv_count = rcv_count + 17'd1;
					rcv_ticks = 32'd0;
					if (rcv_count >= {1'b0, rcv_len})
						rcv_phase = PH_ETX;
					frame_out_due.push_back(result_t'{1'b0, b, ST_OK, rcv_len, 1'b0});
				end
				PH_ETX: begin
					rcv_lrc = rcv_lrc ^ b;
					rcv_ticks = 32'd0;
					rcv_phase = (b == CODE_ETX) ? PH_LRC : PH_LRC_BAD;
				end
				PH_LRC: close_frame((b == rcv_lrc) ? ST_OK : ST_BAD_LRC);
				PH_LRC_BAD: close_frame(ST_BAD_ETX);
				default: ;
			endcase
		end
	endtask

	function automatic int unsigned idle_len(input bit flat, input int unsigned pct_zero);
		int unsigned r;
		if (flat)
			return 0;
		r = $urandom_range(0, 99);
		if (r < pct_zero)
			return 0;
		if (r < 97)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.mode <= MODE_BYTE;
			item_ch.rx_byte <= 8'h00;
			src_gap = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				advance_receiver(item_ch.mode, item_ch.rx_byte);
				items_taken++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					item_ch.valid <= 1'b0;
				end else if (rx_items.size() != 0) begin
					next_item = rx_items.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.mode <= next_item.mode;
					item_ch.rx_byte <= next_item.rx_byte;
					if ($urandom_range(0, 99) == 0)
						src_flat = !src_flat;
					src_gap = idle_len(src_flat, 55);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				seen_res = result_t'{result_ch.is_status, result_ch.payload_byte,
					result_ch.frame_status, result_ch.frame_length, result_ch.last};
				if (frame_out_due.size() == 0) begin
					report_mismatch("result with nothing due", 32'(seen_res), 32'd0);
				end else begin
					due_res = frame_out_due.pop_front();
					if (seen_res.is_status !== due_res.is_status)
						report_mismatch("is_status", seen_res.is_status, due_res.is_status);
					if (seen_res.payload_byte !== due_res.payload_byte)
						report_mismatch("payload_byte", seen_res.payload_byte,
							due_res.payload_byte);
					if (seen_res.frame_status !== due_res.frame_status)
						report_mismatch("frame_status", seen_res.frame_status,
							due_res.frame_status);
					if (seen_res.frame_length !== due_res.frame_length)
						report_mismatch("frame_length", seen_res.frame_length,
							due_res.frame_length);
					if (seen_res.last !== due_res.last)
						report_mismatch("last", seen_res.last, due_res.last);
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(0, 199) == 0)
					snk_flat = !snk_flat;
				snk_gap = idle_len(snk_flat, 75);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_CYCLES) begin
					$display("[%0t] no handshake for %0d cycles", $time, quiet_cycles);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	task automatic queue_item(input logic [1:0] m, input logic [7:0] b);
		rx_items.push_back(rx_item_t'{m, b});
		items_queued++;
	endtask

	task automatic scatter_noise(input int unsigned tick_pct, input int unsigned noise_pct);
		if ($urandom_range(0, 99) < tick_pct)
			repeat ($urandom_range(1, 4)) queue_item(MODE_TICK, 8'($urandom));
		if ($urandom_range(0, 99) < noise_pct)
			queue_item(2'($urandom_range(0, 3)), 8'($urandom));
	endtask

	task automatic queue_frame(input int unsigned len, input int unsigned tick_pct,
		input int unsigned noise_pct, input bit faults);
		logic [15:0] l;
		logic [7:0]  lrc;
		logic [7:0]  b;
		int unsigned cut;
		int unsigned i;
		l = len[15:0];
		cut = (faults && $urandom_range(0, 99) < 4) ? $urandom_range(0, len) : 32'hFFFF_FFFF;
		queue_item(MODE_ARM, 8'($urandom));
		repeat ($urandom_range(0, 2)) begin
			scatter_noise(tick_pct, noise_pct);
			queue_item(MODE_BYTE, CODE_STX ^ 8'($urandom_range(1, 255)));
		end
		scatter_noise(tick_pct, noise_pct);
		queue_item(MODE_BYTE, CODE_STX);
		lrc = 8'h00;
		scatter_noise(tick_pct, noise_pct);
		b = l[15:8];
		queue_item(MODE_BYTE, b);
		lrc = lrc ^ b;
		scatter_noise(tick_pct, noise_pct);
		b = l[7:0];
		queue_item(MODE_BYTE, b);
		lrc = lrc ^ b;
		for (i = 0; i < len; i++) begin
			if (i == cut)
				return;
			scatter_noise(tick_pct, noise_pct);
			b = 8'($urandom);
			queue_item(MODE_BYTE, b);
			lrc = lrc ^ b;
		end
		scatter_noise(tick_pct, noise_pct);
		b = CODE_ETX;
		if (faults && $urandom_range(0, 99) < 6)
			b = CODE_ETX ^ 8'($urandom_range(1, 255));
		queue_item(MODE_BYTE, b);
		lrc = lrc ^ b;
		scatter_noise(tick_pct, noise_pct);
		if (faults && $urandom_range(0, 99) < 6)
			lrc = lrc ^ 8'($urandom_range(1, 255));
		queue_item(MODE_BYTE, lrc);
	endtask

	// frames with random content, closed by a clean frame so the block ends idle
	task automatic run_random(input int unsigned n, input int unsigned tick_pct,
		input int unsigned noise_pct);
		int unsigned stop_at;
		int unsigned r;
		stop_at = items_queued + n;
		while (items_queued < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				queue_frame($urandom_range(0, 6), tick_pct, noise_pct, 1'b1);
			else if (r < 97)
				queue_frame($urandom_range(7, 40), tick_pct, noise_pct, 1'b1);
			else
				queue_frame($urandom_range(250, 260), tick_pct, noise_pct, 1'b1);
		end
		queue_frame($urandom_range(1, 4), 0, 0, 1'b0);
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || frame_out_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_START_TIMEOUT: lim_start = val;
			REG_LENGTH_TIMEOUT: lim_len = val[15:0];
			REG_BYTE_TIMEOUT: lim_b = val[15:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_limits(input logic [31:0] t_start, input logic [15:0] t_len,
		input logic [15:0] t_b);
		write_reg(REG_START_TIMEOUT, t_start);
		write_reg(REG_LENGTH_TIMEOUT, {16'd0, t_len});
		write_reg(REG_BYTE_TIMEOUT, {16'd0, t_b});
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_START_TIMEOUT;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle items, spare mode
		queue_item(MODE_BYTE, 8'hFF);
		queue_item(MODE_TICK, 8'h00);
		queue_item(MODE_SPARE, 8'hAA);
		// zero length frame after a dropped byte
		queue_item(MODE_ARM, 8'h00);
		queue_item(MODE_BYTE, 8'h00);
		queue_item(MODE_BYTE, CODE_STX);
		queue_item(MODE_BYTE, 8'h00);
		queue_item(MODE_BYTE, 8'h00);
		queue_item(MODE_BYTE, CODE_ETX);
		queue_item(MODE_BYTE, 8'h03);
		// wrong end byte
		queue_item(MODE_ARM, 8'hFF);
		queue_item(MODE_BYTE, CODE_STX);
		queue_item(MODE_BYTE, 8'h00);
		queue_item(MODE_BYTE, 8'h01);
		queue_item(MODE_BYTE, 8'hFF);
		queue_item(MODE_BYTE, 8'h55);
		queue_item(MODE_BYTE, 8'h00);
		// re-arm on a maximal header, then a bad check byte
		queue_item(MODE_ARM, 8'h00);
		queue_item(MODE_BYTE, CODE_STX);
		queue_item(MODE_BYTE, 8'hFF);
		queue_item(MODE_BYTE, 8'hFF);
		queue_item(MODE_BYTE, 8'h5A);
		queue_item(MODE_ARM, 8'h00);
		queue_item(MODE_BYTE, CODE_STX);
		queue_item(MODE_BYTE, 8'h00);
		queue_item(MODE_BYTE, 8'h00);
		queue_item(MODE_BYTE, CODE_ETX);
		queue_item(MODE_BYTE, 8'h00);
		wait_idle();

		set_limits($urandom_range(1, 12), 16'($urandom_range(1, 6)),
			16'($urandom_range(1, 6)));
		run_random(150, 12, 3);
		// sender holds until every result is back
		wait_idle();
		run_random(150, 12, 3);
		wait_idle();

		set_limits(32'd1, 16'd1, 16'd1);
		run_random(150, 10, 3);
		wait_idle();

		set_limits(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		run_random(100, 10, 3);
		wait_idle();

		set_limits($urandom_range(2, 20), 16'($urandom_range(1, 10)),
			16'($urandom_range(1, 10)));
		run_random(150, 15, 4);
		wait_idle();

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
